@@ design/rms_silence_split_monitor_core_macros.svh @@
// Assertion macros shared by the silence monitor RTL.
`ifndef RMS_SILENCE_SPLIT_MONITOR_CORE_MACROS_SVH
`define RMS_SILENCE_SPLIT_MONITOR_CORE_MACROS_SVH

// Condition must never hold outside reset.
`define RSSM_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("rssm: forbidden condition seen");

// Antecedent in one cycle forces the consequent in the next, reset included.
`define RSSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rssm: next-cycle check failed");

`endif

@@ design/rssm_pkg.sv @@
// Types and constants of the silence and size monitor.
package rssm_pkg;

    // Fixed field and state widths
    localparam int SUM_W      = 43;
    localparam int FRAMES_W   = 14;
    localparam int CNT32_W    = 32;
    localparam int BYTES_W    = 40;
    localparam int PWR_W      = 31;
    localparam int MS_W       = 22;
    localparam int RATE_W     = 18;
    localparam int SIZE_W     = 16;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int RESULT_W   = 5;
    localparam int OUT_DATA_W = 8;
    localparam int MIB_SHIFT  = 20;
    localparam int BPS_SHIFT  = 2;  // four bytes per sample
    localparam int MS_MUL_W   = 10;
    localparam int LOUD_MUL_W = 7;
    localparam int SCALED_W   = CNT32_W + MS_MUL_W;
    localparam int LIM_W      = MS_W + RATE_W;
    localparam int LOUD_LIM_W = RATE_W + LOUD_MUL_W;

    localparam logic [SUM_W-1:0]      SUM_MAX     = '1;
    localparam logic [CNT32_W-1:0]    CNT32_MAX   = '1;
    localparam logic [BYTES_W-1:0]    BYTES_MAX   = '1;
    localparam logic [MS_MUL_W-1:0]   MS_PER_SEC  = 10'd1000;
    localparam logic [LOUD_MUL_W-1:0] LOUD_CLEAR_MS = 7'd100;

    // Register reset values
    localparam logic [PWR_W-1:0]  PWR_RESET   = 31'd1074;
    localparam logic [MS_W-1:0]   STOP_RESET  = 22'd10000;
    localparam logic [MS_W-1:0]   SPLIT_RESET = 22'd5000;
    localparam logic [RATE_W-1:0] RATE_RESET  = 18'd48000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POWER_THRESHOLD = 3'd0,
        REG_STOP_TIMEOUT    = 3'd1,
        REG_SPLIT_SILENCE   = 3'd2,
        REG_SAMPLE_RATE     = 3'd3,
        REG_WATCH_ENABLE    = 3'd4,
        REG_AUTO_ENABLE     = 3'd5,
        REG_SPLIT_ENABLE    = 3'd6,
        REG_MAX_SIZE        = 3'd7
    } t_cfg_idx;

    // Input opcodes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic [PWR_W-1:0]  power_threshold;
        logic [MS_W-1:0]   stop_timeout_ms;
        logic [MS_W-1:0]   split_silence_ms;
        logic [RATE_W-1:0] sample_rate;
        logic              silence_watch_enable;
        logic              auto_enable;
        logic              split_enable;
        logic [SIZE_W-1:0] max_size_mb;
    } t_cfg;

    // Last field in the lowest bit
    typedef struct packed {
        logic in_silence_episode;
        logic block_silent;
        logic split_on_size;
        logic split_on_silence;
        logic stop_request;
    } t_result;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ design/rms_silence_split_monitor_core.sv @@
// Top level of the RMS silence and size split monitor.
//
// Input stream: one audio sample per transfer. tuser carries the opcode (sample or
// recording restart), tlast marks the last sample of a block, and tdata carries the
// signed sample and, with the last sample, the block's frame count.
// Output stream: one result transfer per block end; samples inside a block and
// restarts give none. tdata holds the stop, split-on-silence, split-on-size,
// block-silent and silence-episode flags.
// Throughput: samples inside a block are taken one per cycle. Each block end holds
// the judge sequencer while it steps through threshold multiply, sum, ms scale and
// decide; a two-record queue absorbs block ends that come while it is busy, after
// which the input stalls. Configuration writes take effect once the registered ms
// limits (products of the settings) follow them; write only while idle.
// Reset (synchronous, active low) restores the register defaults and clears all
// counters; no clearing pass is needed. A stalled receiver holds the result in the
// output register; the front keeps taking samples until the queue fills.
module rms_silence_split_monitor_core
    import rssm_pkg::*;
#(
    parameter int MAX_BLOCK_SAMPLES = 8192,
    parameter int SAMPLE_BITS       = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata: [SAMPLE_BITS-1:0] sample, then block_frames (14 bits), zero pad
    input  logic [((SAMPLE_BITS + FRAMES_W + 7) / 8) * 8 - 1:0] i_s_tdata,
    input  logic                  i_s_tlast,   // last_in_block
    input  logic [0:0]            i_s_tuser,   // opcode
    // Output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: stop_request, split_on_silence, split_on_size, block_silent,
    //        in_silence_episode, zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    `include "rms_silence_split_monitor_core_macros.svh"

    localparam int CNT_W   = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int REC_W   = 1 + SUM_W + CNT_W + FRAMES_W;
    localparam int Q_DEPTH = 2;

    t_cfg             r_cfg;
    t_q_status        q_status;
    t_result          result;
    logic             push;
    logic             pop;
    logic [REC_W-1:0] rec_in;
    logic [REC_W-1:0] rec_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_threshold      <= PWR_RESET;
            r_cfg.stop_timeout_ms      <= STOP_RESET;
            r_cfg.split_silence_ms     <= SPLIT_RESET;
            r_cfg.sample_rate          <= RATE_RESET;
            r_cfg.silence_watch_enable <= 1'b0;
            r_cfg.auto_enable          <= 1'b0;
            r_cfg.split_enable         <= 1'b0;
            r_cfg.max_size_mb          <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_POWER_THRESHOLD: r_cfg.power_threshold      <= i_cfg_data[PWR_W-1:0];
                REG_STOP_TIMEOUT:    r_cfg.stop_timeout_ms      <= i_cfg_data[MS_W-1:0];
                REG_SPLIT_SILENCE:   r_cfg.split_silence_ms     <= i_cfg_data[MS_W-1:0];
                REG_SAMPLE_RATE:     r_cfg.sample_rate          <= i_cfg_data[RATE_W-1:0];
                REG_WATCH_ENABLE:    r_cfg.silence_watch_enable <= i_cfg_data[0];
                REG_AUTO_ENABLE:     r_cfg.auto_enable          <= i_cfg_data[0];
                REG_SPLIT_ENABLE:    r_cfg.split_enable         <= i_cfg_data[0];
                REG_MAX_SIZE:        r_cfg.max_size_mb          <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    rssm_front #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
        .CNT_W             (CNT_W),
        .REC_W             (REC_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_opcode (i_s_tuser[0]),
        .i_sample (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_last   (i_s_tlast),
        .i_frames (i_s_tdata[SAMPLE_BITS +: FRAMES_W]),
        .i_q      (q_status),
        .o_push   (push),
        .o_rec    (rec_in)
    );

    rssm_queue #(
        .WIDTH (REC_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (rec_in),
        .i_pop    (pop),
        .o_data   (rec_out),
        .o_status (q_status)
    );

    rssm_back #(
        .CNT_W (CNT_W),
        .REC_W (REC_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q      (q_status),
        .i_rec    (rec_out),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result)
    );

    assign o_m_tdata = {(OUT_DATA_W - RESULT_W)'(0), result};

    // Queue is never overrun or underrun
    `RSSM_ASSERT_NEVER(a_no_push_full, push && q_status.full)
    `RSSM_ASSERT_NEVER(a_no_pop_empty, pop && q_status.empty)
    // Reset leaves no result pending
    `RSSM_ASSERT_NEXT(a_reset_clears_out, !i_rst_n, !o_m_tvalid)

endmodule

@@ design/rssm_front.sv @@
// Front end: squares samples, accumulates blocks, queues block and restart records.
module rssm_front
    import rssm_pkg::*;
#(
    parameter int SAMPLE_BITS       = 16,
    parameter int MAX_BLOCK_SAMPLES = 8192,
    parameter int CNT_W             = 14,
    parameter int REC_W             = 72
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_opcode,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_last,
    input  logic [FRAMES_W-1:0]    i_frames,
    input  t_q_status              i_q,
    output logic                   o_push,
    output logic [REC_W-1:0]       o_rec
);

    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int ACC_W = ((SUM_W > SQ_W) ? SUM_W : SQ_W) + 1;

    logic                   r_s1_valid;
    logic                   r_s1_op;
    logic                   r_s1_last;
    logic [FRAMES_W-1:0]    r_s1_frames;
    logic [SQ_W-1:0]        r_s1_sq;
    logic [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]       r_cnt;

    logic [SAMPLE_BITS-1:0] mag;
    logic                   s1_push;
    logic                   s1_go;
    logic                   take;
    logic [ACC_W-1:0]       acc_ext;
    logic [SUM_W-1:0]       acc_sat;
    logic [CNT_W-1:0]       cnt_inc;

    // Magnitude of the sample; the most negative code maps to 2^(bits-1)
    always_comb begin
        mag = i_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~i_sample + 1'b1) : i_sample;
    end

    // Advance stage one when it is empty or its item can leave
    always_comb begin
        s1_push = r_s1_op | r_s1_last;
        s1_go   = r_s1_valid && (!s1_push || !i_q.full);
        o_ready = !r_s1_valid || s1_go;
        take    = i_valid && o_ready;
    end

    // Saturating accumulate of square and sample count
    always_comb begin
        acc_ext = ACC_W'(r_sum) + ACC_W'(r_s1_sq);
        acc_sat = (acc_ext > ACC_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(acc_ext);
        cnt_inc = (r_cnt < CNT_W'(MAX_BLOCK_SAMPLES)) ? r_cnt + 1'b1 : r_cnt;
    end

    // Push a record at a block end or a restart
    always_comb begin
        o_push = s1_go && s1_push;
        if (r_s1_op == OP_RESTART) begin
            o_rec = {1'b1, {(REC_W-1){1'b0}}};
        end else begin
            o_rec = {1'b0, acc_sat, cnt_inc, r_s1_frames};
        end
    end

    // Stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage one payload: register the square
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_op     <= i_opcode;
            r_s1_last   <= i_last;
            r_s1_frames <= i_frames;
            r_s1_sq     <= SQ_W'(mag * mag);
        end
    end

    // Block accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (s1_go) begin
            if (s1_push) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= acc_sat;
                r_cnt <= cnt_inc;
            end
        end
    end

endmodule

@@ design/rssm_queue.sv @@
// Short record queue between the front end and the block judge.
module rssm_queue
    import rssm_pkg::*;
#(
    parameter int WIDTH = 72,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              do_push;
    logic              do_pop;

    always_comb begin
        o_status.full  = (r_fill == FILL_W'(DEPTH));
        o_status.empty = (r_fill == '0);
        do_push = i_push && !o_status.full;
        do_pop  = i_pop && !o_status.empty;
        o_data  = r_mem[r_rd_ptr];
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_fill <= r_fill + FILL_W'(do_push) - FILL_W'(do_pop);
        end
    end

endmodule

@@ design/rssm_back.sv @@
// Back end: judges each block, runs the silence episode logic and holds the result.
module rssm_back
    import rssm_pkg::*;
#(
    parameter int CNT_W = 14,
    parameter int REC_W = 72
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_q_status        i_q,
    input  logic [REC_W-1:0] i_rec,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output t_result          o_result
);

    localparam int PROD_W = PWR_W + CNT_W;
    localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_ACC   = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_OUT   = 5'b10000
    } t_bstate;

    t_bstate              r_state;
    t_bstate              n_state;

    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_n;
    logic [FRAMES_W-1:0]  r_frames;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_silent;
    logic [CNT32_W-1:0]   r_cnt_new;
    logic [SCALED_W-1:0]  r_scaled;
    logic [LIM_W-1:0]     r_stop_lim;
    logic [LIM_W-1:0]     r_split_lim;
    logic [LOUD_LIM_W-1:0] r_loud_lim;

    logic [CNT32_W-1:0]   r_sf;
    logic [CNT32_W-1:0]   r_lf;
    logic                 r_flag;
    logic [BYTES_W-1:0]   r_bytes;
    logic                 r_out_valid;
    t_result              r_out;

    logic [RATE_W-1:0]    rate_eff;
    logic                 rec_restart;
    logic                 below;
    logic [CNT32_W:0]     cnt_sum;
    logic [BYTES_W:0]     bytes_sum;
    logic                 out_free;
    logic                 stop_hit;
    logic                 split_hit;
    logic                 loud_hit;
    logic                 size_hit;

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Config-derived limits: ms >= T is frames*1000 >= T*rate
    always_comb begin
        rate_eff = (i_cfg.sample_rate == '0) ? RATE_W'(1) : i_cfg.sample_rate;
    end

    always_ff @(posedge i_clk) begin
        r_stop_lim  <= LIM_W'(i_cfg.stop_timeout_ms * rate_eff);
        r_split_lim <= LIM_W'(i_cfg.split_silence_ms * rate_eff);
        r_loud_lim  <= LOUD_LIM_W'(rate_eff * LOUD_CLEAR_MS);
    end

    // Sequencer
    always_comb begin
        rec_restart = i_rec[REC_W-1];
        o_pop       = (r_state == ST_IDLE) && !i_q.empty;
        out_free    = !r_out_valid || i_ready;
        below       = CMP_W'(r_sum) < CMP_W'(r_prod);
        cnt_sum     = below ? ({1'b0, r_sf} + (CNT32_W + 1)'(r_frames))
                            : ({1'b0, r_lf} + (CNT32_W + 1)'(r_frames));
        bytes_sum   = {1'b0, r_bytes} + (BYTES_W + 1)'({r_n, BPS_SHIFT'(0)});
        stop_hit    = r_scaled >= SCALED_W'(r_stop_lim);
        split_hit   = r_scaled >= SCALED_W'(r_split_lim);
        loud_hit    = r_scaled >= SCALED_W'(r_loud_lim);
        size_hit    = (i_cfg.max_size_mb != '0)
                   && (r_bytes > BYTES_W'({i_cfg.max_size_mb, MIB_SHIFT'(0)}));
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop && !rec_restart) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_ACC;
            ST_ACC:   n_state = ST_SCALE;
            ST_SCALE: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Per-block datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sum    <= i_rec[REC_W-2 -: SUM_W];
            r_n      <= i_rec[FRAMES_W +: CNT_W];
            r_frames <= i_rec[FRAMES_W-1:0];
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(i_cfg.power_threshold * r_n);
        end
        if (r_state == ST_ACC) begin
            r_silent  <= i_cfg.silence_watch_enable && below;
            r_cnt_new <= cnt_sum[CNT32_W] ? CNT32_MAX : cnt_sum[CNT32_W-1:0];
        end
        if (r_state == ST_SCALE) begin
            r_scaled <= SCALED_W'(r_cnt_new * MS_PER_SEC);
        end
    end

    // Episode state, byte total and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf        <= '0;
            r_lf        <= '0;
            r_flag      <= 1'b0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && rec_restart) begin
                r_sf    <= '0;
                r_lf    <= '0;
                r_flag  <= 1'b0;
                r_bytes <= '0;
            end
            if (r_state == ST_ACC) begin
                r_bytes <= bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid             <= 1'b1;
                r_out.stop_request      <= 1'b0;
                r_out.split_on_silence  <= 1'b0;
                r_out.split_on_size     <= size_hit;
                r_out.block_silent      <= r_silent;
                r_out.in_silence_episode <= r_flag;
                if (i_cfg.silence_watch_enable) begin
                    if (r_silent) begin
                        r_sf <= r_cnt_new;
                        r_lf <= '0;
                        if (stop_hit && !r_flag) begin
                            r_flag                   <= 1'b1;
                            r_out.in_silence_episode <= 1'b1;
                            r_out.stop_request       <= i_cfg.auto_enable;
                        end
                        if (i_cfg.split_enable && split_hit) begin
                            r_sf                   <= '0;
                            r_out.split_on_silence <= 1'b1;
                        end
                    end else begin
                        r_lf <= r_cnt_new;
                        if (loud_hit) begin
                            r_sf                     <= '0;
                            r_flag                   <= 1'b0;
                            r_out.in_silence_episode <= 1'b0;
                        end
                    end
                end
            end
        end
    end

endmodule
